/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STEM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define STEM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/stem_pkg.sv */
// Types and constants of the timer expiry manager.
package stem_pkg;

  localparam int MASK_W = 16;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_PERIOD = 2'd1;
  localparam logic [1:0] STAT_IDLE_STOP  = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam logic [4:0] MAX_DISPATCH = 5'd16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot_id;
    logic [31:0] period;
    logic        periodic;
    logic [31:0] now;
    logic [4:0]  dispatch_free;
  } stem_in_t;

  typedef struct packed {
    logic              kind;
    logic [3:0]        expired_id;
    logic [1:0]        status;
    logic [MASK_W-1:0] running_mask;
    logic              last;
  } stem_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_clr;
    logic scan_step;
    logic disp_clear;
    logic disp_reload;
    logic retarget;
    logic emit_hold;
    logic emit_status;
    logic emit_last;
  } stem_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_last;
    logic       found;
    logic       room_left;
    logic       best_per;
    logic       hold_v;
    logic       out_full;
  } stem_stat_t;

endpackage

/* src/stem_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/stem_ctrl.sv */
// Sequencing state machine of the timer expiry manager.
module stem_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stem_pkg::stem_stat_t stat,
  output stem_pkg::stem_ctl_t  ctl
);
  import stem_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_RELOAD = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.exec = 1'b1;
        if (stat.cmd == CMD_TICK) begin
          ctl.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.found) begin
          state_nxt = S_FINISH;
        end else if (!stat.room_left) begin
          ctl.retarget = 1'b1;
          state_nxt    = S_FINISH;
        end else if (!(stat.hold_v && stat.out_full)) begin
          ctl.emit_hold = stat.hold_v;
          if (stat.best_per) begin
            state_nxt = S_RELOAD;
          end else begin
            ctl.disp_clear = 1'b1;
            ctl.scan_clr   = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_RELOAD: begin
        ctl.disp_reload = 1'b1;
        ctl.scan_clr    = 1'b1;
        state_nxt       = S_SCAN;
      end
      S_FINISH: begin
        if (!stat.out_full) begin
          ctl.emit_last   = 1'b1;
          ctl.emit_hold   = stat.hold_v;
          ctl.emit_status = !stat.hold_v;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/stem_dp.sv */
// Datapath: slot flags, period and target memories, due scan, result register.
module stem_dp #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stem_pkg::stem_in_t   in_word,
  input  stem_pkg::stem_ctl_t  ctl,
  output stem_pkg::stem_stat_t stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output stem_pkg::stem_out_t  out_word
);
  import stem_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  stem_in_t              item_r, item_nxt;
  logic [4:0]            room_r, room_nxt;
  logic [4:0]            n_r, n_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [NUM_TIMERS-1:0] active_r, active_nxt;
  logic [NUM_TIMERS-1:0] periodic_r, periodic_nxt;
  logic [CW-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [IW-1:0]         pend_idx_r, pend_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         best_idx_r, best_idx_nxt;
  logic [31:0]           best_tgt_r, best_tgt_nxt;
  logic                  hold_v_r, hold_v_nxt;
  logic [3:0]            hold_id_r, hold_id_nxt;
  logic [MASK_W-1:0]     hold_mask_r, hold_mask_nxt;
  logic                  out_valid_r, out_valid_nxt;
  stem_out_t             out_r, out_nxt;

  logic [IW-1:0]     id_idx;
  logic              id_ok, per_ok, start_ok, stop_ok;
  logic [31:0]       tgt_rd, per_rd;
  logic              tgt_we;
  logic [IW-1:0]     tgt_waddr;
  logic [31:0]       tgt_wdata;
  logic              due, better;
  logic [MASK_W-1:0] mask_cur, mask_clr;

  assign id_idx   = IW'(item_r.slot_id);
  assign id_ok    = ({3'b000, item_r.slot_id} < 7'(NUM_TIMERS));
  assign per_ok   = (item_r.period != 32'd0) && (item_r.period != '1);
  assign start_ok = ctl.exec && (item_r.cmd == CMD_START) && id_ok && per_ok;
  assign stop_ok  = ctl.exec && (item_r.cmd == CMD_STOP) && id_ok && active_r[id_idx];

  genvar gi;
  generate
    for (gi = 0; gi < MASK_W; gi++) begin : g_mask
      if (gi < NUM_TIMERS) begin : g_on
        assign mask_cur[gi] = active_r[gi];
        assign mask_clr[gi] = active_r[gi] && (best_idx_r != IW'(gi));
      end else begin : g_off
        assign mask_cur[gi] = 1'b0;
        assign mask_clr[gi] = 1'b0;
      end
    end
  endgenerate

  assign due    = pend_v_r && active_r[pend_idx_r] && (tgt_rd <= item_r.now);
  assign better = due && (!found_r || (tgt_rd < best_tgt_r));

  always_comb begin
    tgt_we    = 1'b0;
    tgt_waddr = best_idx_r;
    tgt_wdata = item_r.now;
    if (start_ok) begin
      tgt_we    = 1'b1;
      tgt_waddr = id_idx;
      tgt_wdata = item_r.now + item_r.period;
    end else if (ctl.disp_reload) begin
      tgt_we    = 1'b1;
      tgt_wdata = item_r.now + per_rd;
    end else if (ctl.retarget) begin
      tgt_we    = 1'b1;
    end
  end

  stem_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (tgt_waddr),
    .wdata (tgt_wdata),
    .raddr (scan_cnt_r[IW-1:0]),
    .rdata (tgt_rd)
  );

  stem_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_per_ram (
    .clk   (clk),
    .we    (start_ok),
    .waddr (id_idx),
    .wdata (item_r.period),
    .raddr (best_idx_r),
    .rdata (per_rd)
  );

  always_comb begin
    item_nxt      = item_r;
    room_nxt      = room_r;
    n_nxt         = n_r;
    st_nxt        = st_r;
    active_nxt    = active_r;
    periodic_nxt  = periodic_r;
    scan_cnt_nxt  = scan_cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_tgt_nxt  = best_tgt_r;
    hold_v_nxt    = hold_v_r;
    hold_id_nxt   = hold_id_r;
    hold_mask_nxt = hold_mask_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    if (ctl.load) begin
      item_nxt   = in_word;
      room_nxt   = (in_word.dispatch_free > MAX_DISPATCH) ? MAX_DISPATCH
                                                          : in_word.dispatch_free;
      n_nxt      = 5'd0;
      hold_v_nxt = 1'b0;
    end

    if (ctl.exec) begin
      case (item_r.cmd)
        CMD_START: st_nxt = (id_ok && per_ok) ? STAT_OK : STAT_BAD_PERIOD;
        CMD_STOP:  st_nxt = stop_ok ? STAT_OK : STAT_IDLE_STOP;
        default:   st_nxt = STAT_OK;
      endcase
    end
    if (start_ok) begin
      active_nxt[id_idx]   = 1'b1;
      periodic_nxt[id_idx] = item_r.periodic;
    end
    if (stop_ok) begin
      active_nxt[id_idx] = 1'b0;
    end

    if (ctl.scan_clr) begin
      scan_cnt_nxt = '0;
      pend_v_nxt   = 1'b0;
      found_nxt    = 1'b0;
    end
    if (ctl.scan_step) begin
      pend_v_nxt   = (scan_cnt_r < CW'(NUM_TIMERS));
      pend_idx_nxt = scan_cnt_r[IW-1:0];
      if (scan_cnt_r < CW'(NUM_TIMERS)) begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
      end
      if (better) begin
        found_nxt    = 1'b1;
        best_idx_nxt = pend_idx_r;
        best_tgt_nxt = tgt_rd;
      end
    end

    if (ctl.emit_hold) begin
      out_valid_nxt          = 1'b1;
      out_nxt.kind           = KIND_EXPIRY;
      out_nxt.expired_id     = hold_id_r;
      out_nxt.status         = STAT_OK;
      out_nxt.running_mask   = hold_mask_r;
      out_nxt.last           = ctl.emit_last;
      hold_v_nxt             = 1'b0;
    end
    if (ctl.emit_status) begin
      out_valid_nxt          = 1'b1;
      out_nxt.kind           = KIND_STATUS;
      out_nxt.expired_id     = 4'd0;
      out_nxt.status         = st_r;
      out_nxt.running_mask   = mask_cur;
      out_nxt.last           = 1'b1;
    end

    if (ctl.disp_clear) begin
      active_nxt[best_idx_r] = 1'b0;
      hold_v_nxt             = 1'b1;
      hold_id_nxt            = 4'(best_idx_r);
      hold_mask_nxt          = mask_clr;
      n_nxt                  = n_r + 5'd1;
    end
    if (ctl.disp_reload) begin
      hold_v_nxt    = 1'b1;
      hold_id_nxt   = 4'(best_idx_r);
      hold_mask_nxt = mask_cur;
      n_nxt         = n_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      periodic_r  <= '0;
      scan_cnt_r  <= '0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
      hold_v_r    <= 1'b0;
      n_r         <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      periodic_r  <= periodic_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      found_r     <= found_nxt;
      hold_v_r    <= hold_v_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    room_r      <= room_nxt;
    st_r        <= st_nxt;
    pend_idx_r  <= pend_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_tgt_r  <= best_tgt_nxt;
    hold_id_r   <= hold_id_nxt;
    hold_mask_r <= hold_mask_nxt;
    out_r       <= out_nxt;
  end

  assign stat.cmd       = item_r.cmd;
  assign stat.scan_last = (scan_cnt_r == CW'(NUM_TIMERS));
  assign stat.found     = found_r;
  assign stat.room_left = (n_r < room_r);
  assign stat.best_per  = periodic_r[best_idx_r];
  assign stat.hold_v    = hold_v_r;
  assign stat.out_full  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

/* src/software_timer_expiry_manager.sv */
// Top level of the timer expiry manager: controller plus datapath.
// Start, stop, other commands: one status result per word.
// Tick: each due-slot search is a scan of all slots then a decide step, and a periodic
// dispatch adds a reload step; output stalls hold the sequence. One item at a time.
// Synchronous active-low reset clears all slot flags; no memory clearing pass.
module software_timer_expiry_manager #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stem_pkg::stem_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output stem_pkg::stem_out_t out_word
);
  import stem_pkg::*;

  stem_ctl_t  ctl;
  stem_stat_t stat;

  stem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  stem_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .ctl       (ctl),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

/* src/stem_checker.sv */
// Port-level assertions of the timer expiry manager and their bind.
`include "assert_macros.svh"

module stem_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input stem_pkg::stem_in_t  in_word,
  input logic                out_valid,
  input logic                out_ready,
  input stem_pkg::stem_out_t out_word
);
  import stem_pkg::*;

  logic out_status;
  logic out_expiry;

  assign out_status = out_valid && (out_word.kind == KIND_STATUS);
  assign out_expiry = out_valid && (out_word.kind == KIND_EXPIRY);

  `STEM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `STEM_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_word))
  `STEM_ASSERT_IMP(a_status_last, out_status, out_word.last && (out_word.expired_id == 4'd0))
  `STEM_ASSERT_IMP(a_expiry_ok, out_expiry, out_word.status == STAT_OK)
  `STEM_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind software_timer_expiry_manager stem_checker u_stem_checker (.*);

/* dv/software_timer_expiry_manager_tb.sv */
// Self-checking testbench for the timer expiry manager: directed and random words.
`timescale 1ns / 100ps

module software_timer_expiry_manager_tb;
  import stem_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  stem_in_t  in_word;
  logic      out_valid;
  logic      out_ready;
  stem_out_t out_word;

  software_timer_expiry_manager dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  // Shadow timer table
  logic [NUM_SLOTS-1:0] armed;
  logic [NUM_SLOTS-1:0] reload;
  logic [31:0]          interval [NUM_SLOTS];
  logic [31:0]          deadline [NUM_SLOTS];
  stem_out_t            pending_results[$];

  bit          idle_on;
  int          err_count;
  int          quiet_cycles;
  logic [31:0] kernel_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stem_out_t result_word(logic kind, logic [3:0] id, logic [1:0] st);
    stem_out_t r;
    r.kind         = kind;
    r.expired_id   = id;
    r.status       = st;
    r.running_mask = armed;
    r.last         = 1'b0;
    return r;
  endfunction

  // Earliest due slot by deadline, ties to the lower slot; -1 if none
  function automatic int earliest_due(logic [31:0] now_t);
    int best;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (armed[i] && deadline[i] <= now_t && (best < 0 || deadline[i] < deadline[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void predict_word(stem_in_t w);
    stem_out_t batch [NUM_SLOTS];
    int        cnt;
    int        best;
    int        room;
    cnt = 0;
    case (w.cmd)
      CMD_TICK: begin
        room = (w.dispatch_free > MAX_DISPATCH) ? int'(MAX_DISPATCH) : int'(w.dispatch_free);
        best = earliest_due(w.now);
        while (best >= 0 && cnt < room) begin
          if (reload[best]) begin
            deadline[best] = w.now + interval[best];
          end else begin
            armed[best] = 1'b0;
          end
          batch[cnt] = result_word(KIND_EXPIRY, best[3:0], STAT_OK);
          cnt++;
          best = earliest_due(w.now);
        end
        // dispatch room used up: next due slot is pulled in to now
        if (best >= 0) deadline[best] = w.now;
        if (cnt == 0) begin
          batch[0] = result_word(KIND_STATUS, 4'd0, STAT_OK);
          cnt = 1;
        end
      end
      CMD_START: begin
        if (w.period == 32'd0 || w.period == 32'hFFFF_FFFF) begin
          batch[0] = result_word(KIND_STATUS, 4'd0, STAT_BAD_PERIOD);
        end else begin
          armed[w.slot_id]    = 1'b1;
          reload[w.slot_id]   = w.periodic;
          interval[w.slot_id] = w.period;
          deadline[w.slot_id] = w.now + w.period;
          batch[0] = result_word(KIND_STATUS, 4'd0, STAT_OK);
        end
        cnt = 1;
      end
      CMD_STOP: begin
        if (!armed[w.slot_id]) begin
          batch[0] = result_word(KIND_STATUS, 4'd0, STAT_IDLE_STOP);
        end else begin
          armed[w.slot_id] = 1'b0;
          batch[0] = result_word(KIND_STATUS, 4'd0, STAT_OK);
        end
        cnt = 1;
      end
      default: begin
        batch[0] = result_word(KIND_STATUS, 4'd0, STAT_OK);
        cnt = 1;
      end
    endcase
    batch[cnt-1].last = 1'b1;
    for (int i = 0; i < cnt; i++) pending_results.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_word(in_word);
  end

  always @(posedge clk) begin
    stem_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", out_word);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_word.kind);
          err_count++;
        end
        if (out_word.expired_id !== want.expired_id) begin
          $error("expired_id: expected %0d, actual %0d", want.expired_id, out_word.expired_id);
          err_count++;
        end
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_word.status);
          err_count++;
        end
        if (out_word.running_mask !== want.running_mask) begin
          $error("running_mask: expected %h, actual %h", want.running_mask,
                 out_word.running_mask);
          err_count++;
        end
        if (out_word.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_word.last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result-side backpressure
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 15);
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(stem_in_t w);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic stem_in_t make_word(logic [1:0] cmd, logic [3:0] id, logic [31:0] period,
                                         logic periodic, logic [31:0] now_t,
                                         logic [4:0] room);
    stem_in_t w;
    w.cmd           = cmd;
    w.slot_id       = id;
    w.period        = period;
    w.periodic      = periodic;
    w.now           = now_t;
    w.dispatch_free = room;
    return w;
  endfunction

  task automatic test_refused_period();
    send_word(make_word(CMD_START, 4'd0, 32'd0, 1'b1, 32'd50, 5'd0));
    send_word(make_word(CMD_START, 4'd1, 32'hFFFF_FFFF, 1'b0, 32'd50, 5'd0));
    send_word(make_word(CMD_START, 4'd9, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF, 5'd31));
    send_word(make_word(CMD_STOP, 4'd9, 32'd0, 1'b0, 32'd0, 5'd0));
  endtask

  task automatic test_command_status();
    send_word(make_word(CMD_STOP, 4'd2, 32'd7, 1'b1, 32'd0, 5'd3));
    send_word(make_word(CMD_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 5'd31));
    send_word(make_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 5'd16));
  endtask

  // Tie order, restart, partial room, zero room and excess room
  task automatic test_dispatch_order();
    send_word(make_word(CMD_START, 4'd3, 32'd5, 1'b1, 32'd100, 5'd0));
    send_word(make_word(CMD_START, 4'd7, 32'd5, 1'b0, 32'd100, 5'd0));
    send_word(make_word(CMD_START, 4'd5, 32'd2, 1'b0, 32'd100, 5'd0));
    send_word(make_word(CMD_START, 4'd5, 32'd10, 1'b0, 32'd100, 5'd0));
    send_word(make_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'd105, 5'd1));
    send_word(make_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'd106, 5'd0));
    send_word(make_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'd110, 5'd31));
    send_word(make_word(CMD_STOP, 4'd3, 32'd0, 1'b0, 32'd0, 5'd0));
    send_word(make_word(CMD_STOP, 4'd3, 32'd0, 1'b0, 32'd0, 5'd0));
  endtask

  // Reload wraps below now: same slot fires until the room runs out
  task automatic test_wrapping_reload();
    send_word(make_word(CMD_START, 4'd15, 32'hFFFF_FFF0, 1'b1, 32'h10, 5'd0));
    send_word(make_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 5'd16));
    send_word(make_word(CMD_STOP, 4'd15, 32'd0, 1'b0, 32'd0, 5'd0));
  endtask

  function automatic stem_in_t random_word();
    stem_in_t w;
    int       pick;
    int       sel;
    w.cmd           = CMD_TICK;
    w.slot_id       = 4'($urandom_range(0, NUM_SLOTS - 1));
    w.period        = $urandom;
    w.periodic      = 1'($urandom_range(0, 1));
    w.now           = $urandom;
    w.dispatch_free = 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      kernel_now = kernel_now + $urandom_range(0, 6);
      if (pick < 2) kernel_now = $urandom;
      w.now = kernel_now;
      if ($urandom_range(0, 3) != 0) w.dispatch_free = 5'($urandom_range(0, 4));
    end else if (pick < 80) begin
      w.cmd = CMD_START;
      w.now = kernel_now;
      sel = $urandom_range(0, 19);
      if (sel == 0) w.period = 32'd0;
      else if (sel == 1) w.period = 32'hFFFF_FFFF;
      else if (sel > 2) w.period = $urandom_range(1, 30);
    end else if (pick < 95) begin
      w.cmd = CMD_STOP;
    end else begin
      w.cmd = CMD_UNUSED;
    end
    return w;
  endfunction

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    idle_on      = 1'b1;
    err_count    = 0;
    quiet_cycles = 0;
    kernel_now   = 32'd200;
    armed        = '0;
    reload       = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_refused_period();
    test_command_status();
    test_dispatch_order();
    test_wrapping_reload();
    test_random_traffic(151);
    test_back_to_back(40);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
